@@ design/modexp_pkg.sv @@
// Shared types and constants for the modular exponentiation block.
`default_nettype none

package modexp_pkg;

  // Width of the result field; plain mode wraps to this many bits
  localparam int unsigned RESULT_BITS = 32;

  // Command to one bit-serial multiply unit
  typedef struct packed {
    logic start;  // latch operands and begin a product
    logic wrap;   // 1: product wraps to RESULT_BITS, 0: reduce by the modulus
  } mm_cmd_t;

endpackage

`default_nettype wire

@@ design/modexp_mulmod.sv @@
// Bit-serial shift-and-add multiplier with modular or wrapping reduction.
`default_nettype none

module modexp_mulmod #(
  parameter int unsigned DW = 32
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire modexp_pkg::mm_cmd_t cmd_i,
  input  wire logic [DW-1:0]     a_i,
  input  wire logic [DW-1:0]     b_i,
  input  wire logic [DW-1:0]     m_i,
  output logic                   done_o,
  output logic [DW-1:0]          res_o
);
  import modexp_pkg::*;

  localparam int unsigned CW = $clog2(DW);

  logic          busy_q, busy_d;
  logic          phase_q, phase_d;
  logic          done_q, done_d;
  logic [CW-1:0] cnt_q, cnt_d;
  logic [DW-1:0] r_q, r_d;
  logic [DW-1:0] a_q, a_d;
  logic [DW-1:0] b_q, b_d;
  logic [DW-1:0] m_q, m_d;
  logic          wrap_q, wrap_d;

  logic [DW:0]   dbl;
  logic [DW:0]   sum;
  logic [DW:0]   pick;
  logic [DW:0]   sub;
  logic [DW-1:0] red;

  // One add and one compare-subtract per cycle: double, then add the multiplicand
  always_comb begin
    dbl  = {r_q, 1'b0};
    sum  = {1'b0, r_q} + {1'b0, a_q};
    pick = phase_q ? sum : dbl;
    sub  = pick - {1'b0, m_q};
    if (wrap_q) begin
      red = DW'(pick[RESULT_BITS-1:0]);
    end else if (pick >= {1'b0, m_q}) begin
      red = sub[DW-1:0];
    end else begin
      red = pick[DW-1:0];
    end
  end

  // Sequence the multiplier bits from the top: double, then add the multiplicand for a set bit
  always_comb begin
    busy_d  = busy_q;
    phase_d = phase_q;
    done_d  = 1'b0;
    cnt_d   = cnt_q;
    r_d     = r_q;
    a_d     = a_q;
    b_d     = b_q;
    m_d     = m_q;
    wrap_d  = wrap_q;
    if (cmd_i.start) begin
      busy_d  = 1'b1;
      phase_d = 1'b0;
      cnt_d   = CW'(DW - 1);
      r_d     = '0;
      a_d     = a_i;
      b_d     = b_i;
      m_d     = m_i;
      wrap_d  = cmd_i.wrap;
    end else if (busy_q) begin
      if (!phase_q) begin
        r_d     = red;
        phase_d = 1'b1;
      end else begin
        if (b_q[DW-1]) begin
          r_d = red;
        end
        b_d     = {b_q[DW-2:0], 1'b0};
        phase_d = 1'b0;
        if (cnt_q == '0) begin
          busy_d = 1'b0;
          done_d = 1'b1;
        end else begin
          cnt_d = cnt_q - 1'b1;
        end
      end
    end
  end

  // Hold control state under reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q  <= 1'b0;
      phase_q <= 1'b0;
      done_q  <= 1'b0;
      cnt_q   <= '0;
    end else begin
      busy_q  <= busy_d;
      phase_q <= phase_d;
      done_q  <= done_d;
      cnt_q   <= cnt_d;
    end
  end

  // Advance the operand shift registers
  always_ff @(posedge clk_i) begin
    r_q    <= r_d;
    a_q    <= a_d;
    b_q    <= b_d;
    m_q    <= m_d;
    wrap_q <= wrap_d;
  end

  assign done_o = done_q;
  assign res_o  = r_q;

endmodule

`default_nettype wire

@@ design/modular_exponentiation.sv @@
// Top level: right-to-left square-and-multiply exponentiation over stream channels.
//
// Usage: a request enters on the slave stream (s_axis_*) and carries base, exponent
// and modulus in tdata and the mode in tuser (1 modular, 0 plain 32-bit wrap). One
// result leaves on the master stream (m_axis_*): the 32-bit power in tdata and the
// bad-modulus flag in tuser. Each request gives exactly one result transfer.
// Two bit-serial multiply units (DW = max(OPERAND_BITS, 32) bits) set the pace. The
// base is first reduced, then each exponent bit up to the highest set one costs a
// square and, for a set bit, a multiply, the two running side by side. A zero
// exponent still pays for the base reduction; a zero modulus in modular mode skips
// the units and goes from the idle state through the done state to the output
// register. One request is worked on at a time; s_axis_tready_o is high while no
// request is in work, so a new request is taken only once the last result has moved
// to the output register. The result sits in an output register, so the next
// request is taken while a stalled result waits. Reset empties the output register
// and returns the block to idle; a request in work is dropped.
`default_nettype none

module modular_exponentiation #(
  parameter int unsigned OPERAND_BITS = 31
) (
  input  wire logic                                    clk_i,
  input  wire logic                                    rst_ni,
  input  wire logic                                    s_axis_tvalid_i,
  output logic                                         s_axis_tready_o,
  // [OB-1:0] base, [2OB-1:OB] power, [3OB-1:2OB] modulus, rest zero
  input  wire logic [((3*OPERAND_BITS+7)/8)*8-1:0]     s_axis_tdata_i,
  // [0] req_type
  input  wire logic                                    s_axis_tuser_i,
  output logic                                         m_axis_tvalid_o,
  input  wire logic                                    m_axis_tready_i,
  // [31:0] result
  output logic [modexp_pkg::RESULT_BITS-1:0]           m_axis_tdata_o,
  // [0] bad_modulus
  output logic                                         m_axis_tuser_o
);
  import modexp_pkg::*;

  localparam int unsigned DW = (OPERAND_BITS > RESULT_BITS) ? OPERAND_BITS : RESULT_BITS;

  typedef enum logic [4:0] {
    ST_IDLE   = 5'b00001,
    ST_REDUCE = 5'b00010,
    ST_STEP   = 5'b00100,
    ST_MUL    = 5'b01000,
    ST_DONE   = 5'b10000
  } state_e;

  state_e                  state_q, state_d;
  logic                    mode_q, mode_d;
  logic                    bad_q, bad_d;
  logic                    use_a_q, use_a_d;
  logic [OPERAND_BITS-1:0] m_q, m_d;
  logic [OPERAND_BITS-1:0] n_q, n_d;
  logic [DW-1:0]           rs_q, rs_d;
  logic [DW-1:0]           sq_q, sq_d;
  logic                    out_valid_q, out_valid_d;
  logic [RESULT_BITS-1:0]  out_data_q, out_data_d;
  logic                    out_user_q, out_user_d;

  logic [OPERAND_BITS-1:0] in_base;
  logic [OPERAND_BITS-1:0] in_power;
  logic [OPERAND_BITS-1:0] in_mod;
  logic                    in_xfer;
  logic                    out_load;

  mm_cmd_t                 cmd_a, cmd_b;
  logic [DW-1:0]           b_opa, b_opb, mod_op;
  logic                    a_done, b_done;
  logic [DW-1:0]           a_res, b_res;

  assign in_base  = s_axis_tdata_i[OPERAND_BITS-1:0];
  assign in_power = s_axis_tdata_i[2*OPERAND_BITS-1:OPERAND_BITS];
  assign in_mod   = s_axis_tdata_i[3*OPERAND_BITS-1:2*OPERAND_BITS];

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign in_xfer         = s_axis_tvalid_i && s_axis_tready_o;
  assign out_load        = (state_q == ST_DONE) && (!out_valid_q || m_axis_tready_i);

  // Route operands: base reduction on a new request, square otherwise
  always_comb begin
    if (state_q == ST_IDLE) begin
      b_opa  = DW'(1);
      b_opb  = DW'(in_base);
      mod_op = DW'(in_mod);
    end else begin
      b_opa  = sq_q;
      b_opb  = sq_q;
      mod_op = DW'(m_q);
    end
  end

  // Sequence the exponent bits
  always_comb begin
    state_d = state_q;
    mode_d  = mode_q;
    bad_d   = bad_q;
    use_a_d = use_a_q;
    m_d     = m_q;
    n_d     = n_q;
    rs_d    = rs_q;
    sq_d    = sq_q;
    cmd_a   = '{start: 1'b0, wrap: !mode_q};
    cmd_b   = '{start: 1'b0, wrap: !mode_q};
    case (state_q)
      ST_IDLE: begin
        cmd_b.wrap = !s_axis_tuser_i;
        if (in_xfer) begin
          mode_d = s_axis_tuser_i;
          m_d    = in_mod;
          n_d    = in_power;
          if (s_axis_tuser_i && (in_mod == '0)) begin
            rs_d    = '0;
            bad_d   = 1'b1;
            state_d = ST_DONE;
          end else begin
            rs_d        = DW'(1);
            bad_d       = 1'b0;
            cmd_b.start = 1'b1;
            state_d     = ST_REDUCE;
          end
        end
      end
      ST_REDUCE: begin
        if (b_done) begin
          sq_d    = b_res;
          state_d = ST_STEP;
        end
      end
      ST_STEP: begin
        if (n_q == '0) begin
          state_d = ST_DONE;
        end else begin
          cmd_b.start = 1'b1;
          cmd_a.start = n_q[0];
          use_a_d     = n_q[0];
          state_d     = ST_MUL;
        end
      end
      ST_MUL: begin
        if (b_done) begin
          sq_d = b_res;
          if (use_a_q) begin
            rs_d = a_res;
          end
          n_d     = n_q >> 1;
          state_d = ST_STEP;
        end
      end
      ST_DONE: begin
        if (out_load) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Hold the result until the receiver takes it
  always_comb begin
    out_valid_d = out_valid_q;
    out_data_d  = out_data_q;
    out_user_d  = out_user_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_data_d  = rs_q[RESULT_BITS-1:0];
      out_user_d  = bad_q;
    end else if (m_axis_tready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q     <= mode_d;
    bad_q      <= bad_d;
    use_a_q    <= use_a_d;
    m_q        <= m_d;
    n_q        <= n_d;
    rs_q       <= rs_d;
    sq_q       <= sq_d;
    out_data_q <= out_data_d;
    out_user_q <= out_user_d;
  end

  // Multiply unit for the running result
  modexp_mulmod #(
    .DW(DW)
  ) u_mul_a (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_a),
    .a_i    (sq_q),
    .b_i    (rs_q),
    .m_i    (mod_op),
    .done_o (a_done),
    .res_o  (a_res)
  );

  // Multiply unit for the square, also reducing the base
  modexp_mulmod #(
    .DW(DW)
  ) u_mul_b (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .cmd_i  (cmd_b),
    .a_i    (b_opa),
    .b_i    (b_opb),
    .m_i    (mod_op),
    .done_o (b_done),
    .res_o  (b_res)
  );

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = out_data_q;
  assign m_axis_tuser_o  = out_user_q;

  // Both units run the same length, so the result unit never finishes alone
  a_pair_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    a_done |-> b_done)
    else $error("result multiplier finished without the square multiplier");

  // A finished product is only expected while waiting on the units
  a_done_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    b_done |-> (state_q == ST_REDUCE || state_q == ST_MUL))
    else $error("multiplier finished outside a wait state");

  // A bad modulus always carries a zero result
  a_bad_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o) |-> (m_axis_tdata_o == '0))
    else $error("bad modulus flagged with a nonzero result");

endmodule

`default_nettype wire

@@ verif/testbench.sv @@
// Self-checking testbench for the modular exponentiation stream block.
`timescale 1ns / 100ps

module testbench;

  import modexp_pkg::RESULT_BITS;

  localparam int unsigned OPW         = 31;
  localparam int unsigned TDATA_W     = ((3 * OPW + 7) / 8) * 8;
  localparam int unsigned MAX_IDLE    = 18;
  localparam int unsigned HOLD_CYCLES = 4000;
  localparam int unsigned TAIL_CYCLES = 64;
  localparam int unsigned CYCLE_LIMIT = 3000000;

  localparam logic [OPW-1:0] OP_MAX = {OPW{1'b1}};

  typedef enum logic {
    MODE_WRAP    = 1'b0,
    MODE_MODULAR = 1'b1
  } pow_mode_e;

  typedef struct packed {
    logic [RESULT_BITS-1:0] value;
    logic                   bad_modulus;
  } power_result_t;

  logic                   clk_i = 1'b0;
  logic                   rst_ni = 1'b0;
  logic                   s_axis_tvalid = 1'b0;
  logic                   s_axis_tready;
  logic [TDATA_W-1:0]     s_axis_tdata = '0;
  logic                   s_axis_tuser = 1'b0;
  logic                   m_axis_tvalid;
  logic                   m_axis_tready = 1'b0;
  logic [RESULT_BITS-1:0] m_axis_tdata;
  logic                   m_axis_tuser;

  power_result_t expected_powers[$];
  int unsigned   mismatches = 0;
  int unsigned   cycle_count = 0;
  bit            tx_quiet = 1'b0;
  bit            rx_quiet = 1'b0;
  bit            rx_hold_req = 1'b0;

  modular_exponentiation #(
    .OPERAND_BITS(OPW)
  ) dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .s_axis_tvalid_i(s_axis_tvalid),
    .s_axis_tready_o(s_axis_tready),
    .s_axis_tdata_i (s_axis_tdata),
    .s_axis_tuser_i (s_axis_tuser),
    .m_axis_tvalid_o(m_axis_tvalid),
    .m_axis_tready_i(m_axis_tready),
    .m_axis_tdata_o (m_axis_tdata),
    .m_axis_tuser_o (m_axis_tuser)
  );

  // Free-running clock
  initial begin
    forever #6 clk_i = ~clk_i;
  end

  // Right-to-left square-and-multiply; products stay below 2^62 so 64 bits suffice
  function automatic power_result_t predict_power(pow_mode_e mode, logic [OPW-1:0] base,
                                                  logic [OPW-1:0] exponent,
                                                  logic [OPW-1:0] modulus);
    power_result_t   res;
    logic [31:0]     acc32;
    logic [31:0]     sq32;
    logic [63:0]     acc;
    logic [63:0]     sq;
    logic [63:0]     m;
    logic [OPW-1:0]  bits;
    res = '0;
    bits = exponent;
    if (mode == MODE_WRAP) begin
      acc32 = 32'd1;
      sq32 = 32'(base);
      while (bits != '0) begin
        if (bits[0]) acc32 = acc32 * sq32;
        bits = bits >> 1;
        sq32 = sq32 * sq32;
      end
      res.value = acc32;
    end else if (modulus == '0) begin
      res.bad_modulus = 1'b1;
    end else begin
      m = 64'(modulus);
      acc = 64'd1;
      sq = 64'(base) % m;
      while (bits != '0) begin
        if (bits[0]) acc = (sq * acc) % m;
        bits = bits >> 1;
        sq = (sq * sq) % m;
      end
      res.value = acc[RESULT_BITS-1:0];
    end
    return res;
  endfunction

  // Random operand with a random significant width, so short and long values both occur
  function automatic logic [OPW-1:0] rand_operand();
    logic [OPW-1:0] v;
    int unsigned    width;
    v = OPW'($urandom);
    width = $urandom_range(1, OPW);
    return v >> (OPW - width);
  endfunction

  // Offer one request after a random gap (none while tx_quiet) and record its expected result on transfer
  task automatic send_request(pow_mode_e mode, logic [OPW-1:0] base,
                              logic [OPW-1:0] exponent, logic [OPW-1:0] modulus);
    int unsigned gap;
    gap = tx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= TDATA_W'({modulus, exponent, base});
    s_axis_tuser  <= mode;
    do @(posedge clk_i); while (!(s_axis_tvalid && s_axis_tready));
    expected_powers = {expected_powers, predict_power(mode, base, exponent, modulus)};
  endtask

  task automatic send_random_request();
    pow_mode_e      mode;
    logic [OPW-1:0] modulus;
    mode = pow_mode_e'($urandom_range(0, 1));
    modulus = ($urandom_range(0, 15) == 0) ? '0 : rand_operand();
    send_request(mode, rand_operand(), rand_operand(), modulus);
  endtask

  // Drop valid and wait until every outstanding result has been taken
  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_powers.size() != 0) @(posedge clk_i);
  endtask

  // Receiver: random stalls per result, plus a long hold-off on request
  initial begin
    int unsigned stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      if (rx_hold_req) begin
        m_axis_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
        rx_hold_req = 1'b0;
      end
      stall = rx_quiet ? 0 : $urandom_range(0, MAX_IDLE);
      if (stall != 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!(m_axis_tvalid && m_axis_tready) && !rx_hold_req);
    end
  end

  // Compare each result transfer with the oldest expected power
  initial begin
    power_result_t want;
    forever begin
      @(posedge clk_i);
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_powers.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected result: expected none, actual %h/%b",
                   $time, m_axis_tdata, m_axis_tuser);
        end else begin
          want = expected_powers.pop_front();
          if (m_axis_tdata !== want.value) begin
            mismatches++;
            $display("%0t: result mismatch: expected %h, actual %h",
                     $time, want.value, m_axis_tdata);
          end
          if (m_axis_tuser !== want.bad_modulus) begin
            mismatches++;
            $display("%0t: bad_modulus mismatch: expected %b, actual %b",
                     $time, want.bad_modulus, m_axis_tuser);
          end
        end
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  // Field extremes and every special case in both modes
  task automatic test_directed();
    send_request(MODE_WRAP, '0, '0, OPW'(7));
    send_request(MODE_WRAP, '0, OPW'(9), '0);
    send_request(MODE_WRAP, OP_MAX, OP_MAX, '0);
    send_request(MODE_WRAP, OPW'(2), OPW'(31), OPW'(5));
    send_request(MODE_WRAP, OPW'(2), OPW'(32), OP_MAX);
    send_request(MODE_WRAP, OPW'(3), OPW'(20), OP_MAX);
    send_request(MODE_WRAP, OPW'(1), OP_MAX, OPW'(1));
    send_request(MODE_WRAP, OP_MAX, OPW'(1), '0);
    send_request(MODE_WRAP, OP_MAX, OPW'(2), OPW'(123));
    send_request(MODE_WRAP, OPW'(65537), OPW'(3), '0);
    // zero modulus flags an error whatever the exponent
    send_request(MODE_MODULAR, OPW'(5), '0, '0);
    send_request(MODE_MODULAR, OP_MAX, OP_MAX, '0);
    // zero exponent gives 1 even for modulus 1
    send_request(MODE_MODULAR, '0, '0, OPW'(1));
    send_request(MODE_MODULAR, OPW'(7), '0, OPW'(1));
    send_request(MODE_MODULAR, OPW'(7), OPW'(5), OPW'(1));
    send_request(MODE_MODULAR, OP_MAX, OP_MAX, OP_MAX);
    send_request(MODE_MODULAR, OPW'(OP_MAX - 1), OP_MAX, OP_MAX);
    send_request(MODE_MODULAR, OP_MAX, OPW'(1), OPW'(1000));
    send_request(MODE_MODULAR, OPW'(3), OP_MAX, OPW'(2));
    send_request(MODE_MODULAR, '0, OPW'(13), OPW'(97));
    send_request(MODE_MODULAR, OPW'(2), OP_MAX, OPW'(OP_MAX - 2));
    send_request(MODE_MODULAR, OPW'(123456), OPW'(1), OPW'(7));
    send_request(MODE_MODULAR, OP_MAX, OP_MAX, OPW'(OP_MAX - 1));
  endtask

  task automatic test_random_mix();
    repeat (210) send_random_request();
  endtask

  // Hold the receiver off so the output register fills and the input stalls
  task automatic test_output_stall();
    tx_quiet = 1'b1;
    rx_hold_req = 1'b1;
    repeat (8) begin
      send_request(pow_mode_e'($urandom_range(0, 1)), rand_operand(),
                   OPW'($urandom_range(1, 15)), rand_operand() | OPW'(1));
    end
    tx_quiet = 1'b0;
  endtask

  // Pause the sender until every result is back, then resume
  task automatic test_pause_until_drained();
    repeat (6) send_random_request();
    wait_drained();
    repeat (6) send_random_request();
  endtask

  // Neither side idles
  task automatic test_back_to_back();
    tx_quiet = 1'b1;
    rx_quiet = 1'b1;
    repeat (40) send_random_request();
    tx_quiet = 1'b0;
    rx_quiet = 1'b0;
  endtask

  initial begin
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random_mix();
    test_output_stall();
    test_pause_until_drained();
    test_back_to_back();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

@@ filelist.f @@
design/modexp_pkg.sv
design/modexp_mulmod.sv
design/modular_exponentiation.sv
verif/testbench.sv
